>>> hw/rtl/kdhr_pkg.sv
// ----------------------------------------------------------------------------
// kdhr_pkg
// shared types, constants and the scancode table of the keypad debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package kdhr_pkg;

  // keypad geometry
  localparam int NUM_KEYS = 12;
  localparam int KEY_W    = 4;
  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd9;
  localparam logic [KEY_W-1:0] KEY_ZERO = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  // report layout
  localparam int NUM_SLOTS  = 6;
  localparam int SLOT_W     = 6;
  localparam int SLOT_CNT_W = 3;
  localparam int MOD_W      = 2;
  localparam int OUT_CNT_W  = 16;

  localparam logic [MOD_W-1:0] MOD_NONE       = 2'd0;
  localparam logic [MOD_W-1:0] MOD_LEFT_SHIFT = 2'd2;

  localparam logic [SLOT_W-1:0] CODE_KEY_ONE = 6'h1e;
  localparam logic [SLOT_W-1:0] CODE_ZERO    = 6'h27;
  localparam logic [SLOT_W-1:0] CODE_HASH    = 6'h05;
  localparam logic [SLOT_W-1:0] CODE_STAR    = 6'h04;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 2'd1;
  localparam logic [CFG_DATA_W-1:0] PRESS_TICKS_RST   = 8'd5;
  localparam logic [CFG_DATA_W-1:0] RELEASE_TICKS_RST = 8'd20;

  // parameter defaults
  localparam int TIMER_WIDTH_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // one key update leaving the sweep
  typedef struct packed {
    logic             fire;
    logic             first;
    logic             last;
    logic             sel_hit;
    logic             commit;
    logic             pressed;
    logic [KEY_W-1:0] key;
  } kdhr_upd_t;

  function automatic logic [SLOT_W-1:0] key_code(input logic [KEY_W-1:0] key);
    logic [SLOT_W-1:0] code;
    case (key)
      KEY_STAR: code = CODE_STAR;
      KEY_ZERO: code = CODE_ZERO;
      KEY_HASH: code = CODE_HASH;
      default:  code = CODE_KEY_ONE + SLOT_W'(key);
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kdhr_ram.sv
// ----------------------------------------------------------------------------
// kdhr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module kdhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/kdhr_sweep.sv
// ----------------------------------------------------------------------------
// kdhr_sweep
// walks the keys of each item through the per-key state ram, read then update
// ----------------------------------------------------------------------------
`default_nettype none

module kdhr_sweep
  import kdhr_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  input  wire logic [NUM_KEYS-1:0]    item_raw_i,
  input  wire logic [KEY_W-1:0]       item_sel_i,
  output logic                        item_take_o,
  input  wire logic [TIMER_WIDTH-1:0] press_reload_i,
  input  wire logic [TIMER_WIDTH-1:0] release_reload_i,
  input  wire logic                   res_ready_i,
  output kdhr_upd_t                   upd_o,
  output logic      [COUNT_WIDTH-1:0] count_o,
  output logic      [COUNT_WIDTH-1:0] bounce_o,
  output logic      [COUNT_WIDTH-1:0] phantom_o,
  output logic      [NUM_KEYS-1:0]    stable_o
);

  localparam int ENT_W = TIMER_WIDTH + COUNT_WIDTH;

  // issue stage
  logic                busy_q, busy_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [NUM_KEYS-1:0] cur_raw_q;
  logic [KEY_W-1:0]    cur_sel_q;
  logic                hold, issue_fire, last_issue, item_take;

  // update stage
  logic             upd_valid_q;
  logic [KEY_W-1:0] upd_key_q;
  logic             upd_raw_bit_q, upd_sel_hit_q, upd_first_q, upd_last_q;
  logic             upd_ent_valid_q;
  logic             upd_fire;

  // scalar state
  logic [NUM_KEYS-1:0]    deb_q, deb_d, last_raw_q, last_raw_d;
  logic [NUM_KEYS-1:0]    ent_valid_q;
  logic [COUNT_WIDTH-1:0] bounce_q, bounce_d, phantom_q, phantom_d;

  logic [ENT_W-1:0]       rdata;
  logic [TIMER_WIDTH-1:0] timer_old, timer_new;
  logic [COUNT_WIDTH-1:0] cnt_old, cnt_new;
  logic                   commit;

  assign hold       = upd_valid_q & upd_last_q & ~res_ready_i;
  assign issue_fire = busy_q & ~hold;
  assign last_issue = issue_fire & (key_q == LAST_KEY);
  assign item_take  = item_valid_i & (~busy_q | last_issue);
  assign upd_fire   = upd_valid_q & ~hold;

  always_comb begin
    busy_d = busy_q;
    key_d  = key_q;
    if (item_take) begin
      busy_d = 1'b1;
      key_d  = '0;
    end else if (last_issue) begin
      busy_d = 1'b0;
    end else if (issue_fire) begin
      key_d = key_q + KEY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      key_q       <= '0;
      upd_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      key_q  <= key_d;
      if (!hold) begin
        upd_valid_q <= issue_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take) begin
      cur_raw_q <= item_raw_i;
      cur_sel_q <= item_sel_i;
    end
    if (!hold) begin
      upd_key_q       <= key_q;
      upd_raw_bit_q   <= cur_raw_q[key_q];
      upd_sel_hit_q   <= (cur_sel_q == key_q);
      upd_first_q     <= (key_q == '0);
      upd_last_q      <= (key_q == LAST_KEY);
      upd_ent_valid_q <= ent_valid_q[key_q];
    end
  end

  kdhr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_KEYS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (upd_fire),
    .waddr_i (upd_key_q),
    .wdata_i ({cnt_new, timer_new}),
    .re_i    (issue_fire),
    .raddr_i (key_q),
    .rdata_o (rdata)
  );

  // entries never written read as zero
  assign timer_old = upd_ent_valid_q ? rdata[TIMER_WIDTH-1:0] : '0;
  assign cnt_old   = upd_ent_valid_q ? rdata[TIMER_WIDTH +: COUNT_WIDTH] : '0;

  always_comb begin
    timer_new  = timer_old;
    cnt_new    = cnt_old;
    deb_d      = deb_q;
    last_raw_d = last_raw_q;
    bounce_d   = bounce_q;
    phantom_d  = phantom_q;
    commit     = 1'b0;
    if (upd_fire) begin
      if (last_raw_q[upd_key_q] != upd_raw_bit_q) begin
        // raw edge: restart the countdown
        last_raw_d[upd_key_q] = upd_raw_bit_q;
        timer_new = deb_q[upd_key_q] ? press_reload_i : release_reload_i;
        bounce_d  = bounce_q + COUNT_WIDTH'(1);
      end else if (timer_old != '0) begin
        timer_new = timer_old - TIMER_WIDTH'(1);
        if (timer_old == TIMER_WIDTH'(1)) begin
          if (deb_q[upd_key_q] != upd_raw_bit_q) begin
            deb_d[upd_key_q] = upd_raw_bit_q;
            if (!upd_raw_bit_q) begin
              cnt_new = cnt_old + COUNT_WIDTH'(1);
            end
            commit   = 1'b1;
            bounce_d = bounce_q - COUNT_WIDTH'(1);
          end else begin
            phantom_d = phantom_q + COUNT_WIDTH'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q       <= '1;
      last_raw_q  <= '1;
      bounce_q    <= '0;
      phantom_q   <= '0;
      ent_valid_q <= '0;
    end else begin
      deb_q      <= deb_d;
      last_raw_q <= last_raw_d;
      bounce_q   <= bounce_d;
      phantom_q  <= phantom_d;
      if (upd_fire) begin
        ent_valid_q[upd_key_q] <= 1'b1;
      end
    end
  end

  assign item_take_o   = item_take;
  assign upd_o.fire    = upd_fire;
  assign upd_o.first   = upd_first_q;
  assign upd_o.last    = upd_last_q;
  assign upd_o.sel_hit = upd_sel_hit_q;
  assign upd_o.commit  = commit;
  assign upd_o.pressed = ~deb_d[upd_key_q];
  assign upd_o.key     = upd_key_q;
  assign count_o       = cnt_new;
  assign bounce_o      = bounce_d;
  assign phantom_o     = phantom_d;
  assign stable_o      = deb_d;

`ifndef NO_ASSERTIONS
  // read and write never hit the same entry in one cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue_fire && upd_fire) |-> (key_q != upd_key_q))
    else $error("state ram read and write collide");

  // when an item closes, the next one has not yet gone past its first key
  a_item_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_valid_q && upd_last_q && busy_q) |-> (key_q == '0))
    else $error("next item issued ahead of previous item's last key");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/kdhr_report.sv
// ----------------------------------------------------------------------------
// kdhr_report
// builds the boot report during the sweep and holds the finished result item
// ----------------------------------------------------------------------------
`default_nettype none

module kdhr_report
  import kdhr_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire kdhr_upd_t              upd_i,
  input  wire logic [COUNT_WIDTH-1:0] count_i,
  input  wire logic [COUNT_WIDTH-1:0] bounce_i,
  input  wire logic [COUNT_WIDTH-1:0] phantom_i,
  input  wire logic [NUM_KEYS-1:0]    stable_i,
  output logic                        res_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        changed_o,
  output logic      [NUM_KEYS-1:0]    stable_keys_o,
  output logic      [MOD_W-1:0]       modifier_o,
  output logic      [SLOT_W-1:0]      slot_one_o,
  output logic      [SLOT_W-1:0]      slot_two_o,
  output logic      [SLOT_W-1:0]      slot_three_o,
  output logic      [SLOT_W-1:0]      slot_four_o,
  output logic      [SLOT_W-1:0]      slot_five_o,
  output logic      [SLOT_W-1:0]      slot_six_o,
  output logic      [OUT_CNT_W-1:0]   bounce_total_o,
  output logic      [OUT_CNT_W-1:0]   phantom_total_o,
  output logic      [OUT_CNT_W-1:0]   press_total_o
);

  // accumulators over one sweep
  logic                   chg_q;
  logic [SLOT_CNT_W-1:0]  cnt_q;
  logic [COUNT_WIDTH-1:0] press_q;
  logic [SLOT_W-1:0]      slots_q [NUM_SLOTS];

  logic                   prior_chg, new_chg, place;
  logic [SLOT_CNT_W-1:0]  prior_cnt, new_cnt;
  logic [COUNT_WIDTH-1:0] prior_press, new_press;
  logic [SLOT_W-1:0]      new_slots [NUM_SLOTS];
  logic                   load;

  // result register
  logic                   out_valid_q;
  logic                   out_chg_q;
  logic [NUM_KEYS-1:0]    out_stable_q;
  logic [SLOT_W-1:0]      out_slots_q [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] out_bounce_q, out_phantom_q, out_press_q;

  always_comb begin
    prior_chg   = upd_i.first ? 1'b0 : chg_q;
    prior_cnt   = upd_i.first ? '0 : cnt_q;
    prior_press = upd_i.first ? '0 : press_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      new_slots[i] = upd_i.first ? '0 : slots_q[i];
    end
    // key state is final once its own update is done
    place = upd_i.pressed && (upd_i.key != KEY_STAR) &&
            (prior_cnt < SLOT_CNT_W'(NUM_SLOTS));
    if (place) begin
      new_slots[prior_cnt] = key_code(upd_i.key);
    end
    new_cnt   = prior_cnt + SLOT_CNT_W'(place);
    new_chg   = prior_chg | upd_i.commit;
    new_press = upd_i.sel_hit ? count_i : prior_press;
  end

  assign load        = upd_i.fire & upd_i.last;
  assign res_ready_o = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (upd_i.fire) begin
        cnt_q <= new_cnt;
      end
      out_valid_q <= load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.fire) begin
      chg_q   <= new_chg;
      press_q <= new_press;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots_q[i] <= new_slots[i];
      end
    end
    if (load) begin
      out_chg_q     <= new_chg;
      out_stable_q  <= stable_i;
      out_bounce_q  <= bounce_i;
      out_phantom_q <= phantom_i;
      out_press_q   <= new_press;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        out_slots_q[i] <= new_slots[i];
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign changed_o       = out_chg_q;
  assign stable_keys_o   = out_stable_q;
  assign modifier_o      = out_stable_q[KEY_STAR] ? MOD_NONE : MOD_LEFT_SHIFT;
  assign slot_one_o      = out_slots_q[0];
  assign slot_two_o      = out_slots_q[1];
  assign slot_three_o    = out_slots_q[2];
  assign slot_four_o     = out_slots_q[3];
  assign slot_five_o     = out_slots_q[4];
  assign slot_six_o      = out_slots_q[5];
  assign bounce_total_o  = OUT_CNT_W'(out_bounce_q);
  assign phantom_total_o = OUT_CNT_W'(out_phantom_q);
  assign press_total_o   = OUT_CNT_W'(out_press_q);

`ifndef NO_ASSERTIONS
  // a finished item never lands on a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten before it was taken");

  // slot fill never runs past the report
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOT_CNT_W'(NUM_SLOTS))
    else $error("slot count beyond report size");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/keypad_debounce_hid_report.sv
// ----------------------------------------------------------------------------
// keypad_debounce_hid_report
// per-key countdown debouncer for a 12-key keypad with a boot keyboard report
// ----------------------------------------------------------------------------
// Each input item is one raw sample of the 12 active-low keys (1..9, *, 0, #)
// plus a key select. The block debounces every key with its own countdown,
// reloaded with the press or release tick count on a raw edge, and returns one
// result item per sample: the debounced keys, a changed flag, the bounce and
// phantom totals, the press count of the selected key and a boot keyboard
// report (left shift for '*', up to six scancodes in key order). Per-key
// countdowns and press counters live in a 12-entry state ram that is walked
// one key per cycle, read then update and write back, unless a finished sample
// waits on a stalled result register; the next sample is taken as the current
// one's last key is read. A one-item input buffer takes the next sample while
// the current one is swept, and the result register lets the sweep run on while
// a result waits. Entry valid bits clear on reset, so there is no clearing
// pass. The user must write the tick registers through the cfg port only while
// the block is idle; the block does not check it. Index 0 press ticks, index
// 1 release ticks, other indexes ignored; both are cut to TIMER_WIDTH bits.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_debounce_hid_report
  import kdhr_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [NUM_KEYS-1:0]   raw_keys_i,
  input  wire logic [KEY_W-1:0]      count_select_i,
  // result items
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       changed_o,
  output logic      [NUM_KEYS-1:0]   stable_keys_o,
  output logic      [MOD_W-1:0]      modifier_o,
  output logic      [SLOT_W-1:0]     slot_one_o,
  output logic      [SLOT_W-1:0]     slot_two_o,
  output logic      [SLOT_W-1:0]     slot_three_o,
  output logic      [SLOT_W-1:0]     slot_four_o,
  output logic      [SLOT_W-1:0]     slot_five_o,
  output logic      [SLOT_W-1:0]     slot_six_o,
  output logic      [OUT_CNT_W-1:0]  bounce_total_o,
  output logic      [OUT_CNT_W-1:0]  phantom_total_o,
  output logic      [OUT_CNT_W-1:0]  press_total_o
);

  // tick registers
  logic [CFG_DATA_W-1:0] press_ticks_q, release_ticks_q;

  // input buffer, one item deep
  logic                buf_valid_q;
  logic [NUM_KEYS-1:0] buf_raw_q;
  logic [KEY_W-1:0]    buf_sel_q;
  logic                in_accept, item_take;

  // sweep to report
  kdhr_upd_t              upd;
  logic [COUNT_WIDTH-1:0] count, bounce, phantom;
  logic [NUM_KEYS-1:0]    stable;
  logic                   res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_ticks_q   <= PRESS_TICKS_RST;
      release_ticks_q <= RELEASE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PRESS_TICKS:   press_ticks_q   <= cfg_data_i;
        REG_RELEASE_TICKS: release_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // buffer frees up in the same cycle the sweep takes its item
  assign in_stall_o = buf_valid_q & ~item_take;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= in_accept | (buf_valid_q & ~item_take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      buf_raw_q <= raw_keys_i;
      buf_sel_q <= count_select_i;
    end
  end

  kdhr_sweep #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sweep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (buf_valid_q),
    .item_raw_i       (buf_raw_q),
    .item_sel_i       (buf_sel_q),
    .item_take_o      (item_take),
    .press_reload_i   (TIMER_WIDTH'(press_ticks_q)),
    .release_reload_i (TIMER_WIDTH'(release_ticks_q)),
    .res_ready_i      (res_ready),
    .upd_o            (upd),
    .count_o          (count),
    .bounce_o         (bounce),
    .phantom_o        (phantom),
    .stable_o         (stable)
  );

  kdhr_report #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_report (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_i           (upd),
    .count_i         (count),
    .bounce_i        (bounce),
    .phantom_i       (phantom),
    .stable_i        (stable),
    .res_ready_o     (res_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .changed_o       (changed_o),
    .stable_keys_o   (stable_keys_o),
    .modifier_o      (modifier_o),
    .slot_one_o      (slot_one_o),
    .slot_two_o      (slot_two_o),
    .slot_three_o    (slot_three_o),
    .slot_four_o     (slot_four_o),
    .slot_five_o     (slot_five_o),
    .slot_six_o      (slot_six_o),
    .bounce_total_o  (bounce_total_o),
    .phantom_total_o (phantom_total_o),
    .press_total_o   (press_total_o)
  );

endmodule

`default_nettype wire
